// ===== hdl/pzb_pkg.sv =====
// shared types, constants and bar tables for the postnet zip/bar codec
// no dependencies; imported by every module of the block
package pzb_pkg;

  localparam int ZIP_IN_W    = 17;
  localparam int ZIP_OUT_W   = 18;
  localparam int BARS_W      = 27;
  localparam int GROUP_W     = 5;
  localparam int NUM_GROUPS  = 5;
  localparam int DIGIT_W     = 4;
  localparam int REM_W       = 10;
  localparam int QUEUE_DEPTH = 2;

  // direction codes carried by the mode field
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // one classified word waiting between front and back
  typedef struct packed {
    logic                                 mode;
    logic [ZIP_IN_W-1:0]                  zip;
    logic [BARS_W-1:0]                    bars;
    logic [NUM_GROUPS-1:0][DIGIT_W-1:0]   digit;
    logic [REM_W-1:0]                     rem;
    logic                                 bad_frame;
    logic                                 bad_group;
  } pzb_item_t;

  // two-of-five pattern for a digit, all half bars for a digit above nine
  function automatic logic [GROUP_W-1:0] digit_bars(input logic [DIGIT_W-1:0] d);
    logic [GROUP_W-1:0] pat;
    case (d)
      4'd0:    pat = 5'b11000;
      4'd1:    pat = 5'b00011;
      4'd2:    pat = 5'b00101;
      4'd3:    pat = 5'b00110;
      4'd4:    pat = 5'b01001;
      4'd5:    pat = 5'b01010;
      4'd6:    pat = 5'b01100;
      4'd7:    pat = 5'b10001;
      4'd8:    pat = 5'b10010;
      4'd9:    pat = 5'b10100;
      default: pat = 5'b00000;
    endcase
    return pat;
  endfunction

  // 7-4-2-1-0 weighted sum of a group, eleven reads as zero
  function automatic logic [DIGIT_W-1:0] group_value(input logic [GROUP_W-1:0] g);
    logic [DIGIT_W-1:0] s;
    s = (g[4] ? 4'd7 : 4'd0) + (g[3] ? 4'd4 : 4'd0)
      + (g[2] ? 4'd2 : 4'd0) + (g[1] ? 4'd1 : 4'd0);
    if (s == 4'd11) begin
      s = 4'd0;
    end
    return s;
  endfunction

  // digit times the decimal weight of its group, first group highest
  function automatic logic [ZIP_OUT_W-1:0] place_value(input int k,
                                                       input logic [DIGIT_W-1:0] d);
    logic [ZIP_OUT_W-1:0] w;
    case (k)
      0:       w = 18'd10000;
      1:       w = 18'd1000;
      2:       w = 18'd100;
      3:       w = 18'd10;
      default: w = 18'd1;
    endcase
    return ZIP_OUT_W'(ZIP_OUT_W'(d) * w);
  endfunction

endpackage

// ===== hdl/pzb_front.sv =====
// front end: classifies each incoming word by direction and does the first half
// of the work (upper two zip digits, or all group values and flags); uses pzb_pkg
module pzb_front import pzb_pkg::*; (
  input  logic                mode,
  input  logic [ZIP_IN_W-1:0] zip_in,
  input  logic [BARS_W-1:0]   bars_in,
  output pzb_item_t           item
);

  logic [DIGIT_W-1:0]  d0;
  logic [DIGIT_W-1:0]  d1;
  logic [ZIP_IN_W-1:0] rem0;
  logic [ZIP_IN_W-1:0] rem1;
  logic [NUM_GROUPS-1:0][DIGIT_W-1:0] gval;
  logic                any_big;

  // ten-thousands digit by threshold compare, then the thousands digit
  always_comb begin
    d0 = '0;
    for (int k = 1; k <= 13; k++) begin
      if (zip_in >= ZIP_IN_W'(k * 10000)) begin
        d0 = DIGIT_W'(k);
      end
    end
    rem0 = zip_in - ZIP_IN_W'(ZIP_IN_W'(d0) * ZIP_IN_W'(10000));
    d1 = '0;
    for (int k = 1; k <= 9; k++) begin
      if (rem0 >= ZIP_IN_W'(k * 1000)) begin
        d1 = DIGIT_W'(k);
      end
    end
    rem1 = rem0 - ZIP_IN_W'(ZIP_IN_W'(d1) * ZIP_IN_W'(1000));
  end

  // group values for decoding, first group sits just below the leading frame bar
  always_comb begin
    any_big = 1'b0;
    for (int k = 0; k < NUM_GROUPS; k++) begin
      gval[k] = group_value(bars_in[BARS_W-1-GROUP_W*(k+1) +: GROUP_W]);
      if (gval[k] > 4'd9) begin
        any_big = 1'b1;
      end
    end
  end

  // pack the classified word
  always_comb begin
    item.mode = mode;
    item.zip  = zip_in;
    item.bars = bars_in;
    if (mode == MODE_DECODE) begin
      item.digit     = gval;
      item.rem       = '0;
      item.bad_frame = !bars_in[BARS_W-1] || !bars_in[0];
      item.bad_group = any_big;
    end else begin
      item.digit     = '0;
      item.digit[0]  = d0;
      item.digit[1]  = d1;
      item.rem       = rem1[REM_W-1:0];
      item.bad_frame = 1'b0;
      item.bad_group = 1'b0;
    end
  end

endmodule

// ===== hdl/pzb_queue.sv =====
// short register queue between front and back so each side stalls on its own
// uses pzb_pkg for the word type
module pzb_queue import pzb_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  pzb_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output pzb_item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pzb_item_t          slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // fill count stays within depth, follows pushes and pops and the pointers
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1)
    else $error("queue count missed a pop");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CNT_W'(DEPTH)) |-> wr_ptr == rd_ptr)
    else $error("queue pointers out of step with count");

endmodule

// ===== hdl/pzb_back.sv =====
// back end: finishes the lower digits and bar pattern, or combines decoded
// digits into the zip value, into the output register; uses pzb_pkg
module pzb_back import pzb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  pzb_item_t            item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ZIP_OUT_W-1:0] zip_out,
  output logic [BARS_W-1:0]    bars_out,
  output logic                 bad_frame,
  output logic                 bad_group
);

  logic [DIGIT_W-1:0]   d2;
  logic [DIGIT_W-1:0]   d3;
  logic [DIGIT_W-1:0]   d4;
  logic [REM_W-1:0]     rem2;
  logic [REM_W-1:0]     rem3;
  logic [BARS_W-1:0]    code;
  logic [ZIP_OUT_W-1:0] value;
  logic                 take;

  assign item_ready = !out_valid || out_ready;
  assign take       = item_valid && item_ready;

  // hundreds, tens and units from the remainder below one thousand
  always_comb begin
    d2 = '0;
    for (int k = 1; k <= 9; k++) begin
      if (item.rem >= REM_W'(k * 100)) begin
        d2 = DIGIT_W'(k);
      end
    end
    rem2 = item.rem - REM_W'(REM_W'(d2) * REM_W'(100));
    d3 = '0;
    for (int k = 1; k <= 9; k++) begin
      if (rem2 >= REM_W'(k * 10)) begin
        d3 = DIGIT_W'(k);
      end
    end
    rem3 = rem2 - REM_W'(REM_W'(d3) * REM_W'(10));
    d4   = rem3[DIGIT_W-1:0];
  end

  // framed bar pattern
  assign code = {1'b1, digit_bars(item.digit[0]), digit_bars(item.digit[1]),
                 digit_bars(d2), digit_bars(d3), digit_bars(d4), 1'b1};

  // decimal combine of the decoded group values
  always_comb begin
    value = '0;
    for (int k = 0; k < NUM_GROUPS; k++) begin
      value = value + place_value(k, item.digit[k]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_ready) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      bad_frame <= item.bad_frame;
      bad_group <= item.bad_group;
      if (item.mode == MODE_DECODE) begin
        zip_out  <= value;
        bars_out <= item.bars;
      end else begin
        zip_out  <= ZIP_OUT_W'(item.zip);
        bars_out <= code;
      end
    end
  end

endmodule

// ===== hdl/postnet_zip_bar_codec.sv =====
// channel | handshake          | payload
// in      | in_valid/in_ready   | mode, zip_in, bars_in
// out     | out_valid/out_ready | zip_out, bars_out, bad_frame, bad_group
//
// one word per cycle sustained while out_ready holds; an accepted word
// passes a queue slot, then the output register, when the output is free
// the front digit split and group sums feed a queue of QUEUE_DEPTH words
// input ready drops only when the queue is full; the output register refills
// in the cycle its word is taken
// synchronous active-high reset empties the queue and the output register
// top level: front end, queue and back end; uses pzb_pkg
module postnet_zip_bar_codec import pzb_pkg::*; #(
  parameter int QUEUE_DEPTH = pzb_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 mode,
  input  logic [ZIP_IN_W-1:0]  zip_in,
  input  logic [BARS_W-1:0]    bars_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ZIP_OUT_W-1:0] zip_out,
  output logic [BARS_W-1:0]    bars_out,
  output logic                 bad_frame,
  output logic                 bad_group
);

  pzb_item_t front_item;
  pzb_item_t back_item;
  logic      back_valid;
  logic      back_ready;

  // classify incoming words
  pzb_front u_front (
    .mode    (mode),
    .zip_in  (zip_in),
    .bars_in (bars_in),
    .item    (front_item)
  );

  // decoupling queue
  pzb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (front_item),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_item   (back_item)
  );

  // finish conversion into the output register
  pzb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (back_valid),
    .item_ready (back_ready),
    .item       (back_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .zip_out    (zip_out),
    .bars_out   (bars_out),
    .bad_frame  (bad_frame),
    .bad_group  (bad_group)
  );

endmodule

// ===== verif/tb_postnet_zip_bar_codec.sv =====
// self-checking testbench for the postnet zip/bar codec: directed vectors, then random words
// depends on pzb_pkg and postnet_zip_bar_codec from hdl/
module tb_postnet_zip_bar_codec import pzb_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // one result word as seen on the output channel
  typedef struct packed {
    logic [ZIP_OUT_W-1:0] zip;
    logic [BARS_W-1:0]    bars;
    logic                 bad_frame;
    logic                 bad_group;
  } postnet_word_t;

  // directed vector: input fields, then a typed result where chk is set
  typedef struct packed {
    logic                 mode;
    logic [ZIP_IN_W-1:0]  zip;
    logic [BARS_W-1:0]    bars;
    logic                 chk;
    logic [ZIP_OUT_W-1:0] ezip;
    logic [BARS_W-1:0]    ebars;
    logic                 ebf;
    logic                 ebg;
  } vector_row_t;

  localparam int NUM_ROWS     = 20;
  localparam int RANDOM_WORDS = 750;
  localparam int CALM_FIRST   = 300;
  localparam int CALM_LAST    = 449;
  localparam int DRAIN_AT     = 500;

  // two-of-five bar groups for digits 0 to 9
  localparam logic [GROUP_W-1:0] TWO_OF_FIVE [10] = '{
    5'b11000, 5'b00011, 5'b00101, 5'b00110, 5'b01001,
    5'b01010, 5'b01100, 5'b10001, 5'b10010, 5'b10100
  };

  localparam vector_row_t VECTORS [NUM_ROWS] = '{
    '{MODE_ENCODE, 17'd0, 27'd0, 1'b1, 18'd0,
      27'b1_11000_11000_11000_11000_11000_1, 1'b0, 1'b0},
    '{MODE_ENCODE, 17'd99999, 27'h7FFFFFF, 1'b1, 18'd99999,
      27'b1_10100_10100_10100_10100_10100_1, 1'b0, 1'b0},
    '{MODE_ENCODE, 17'd131071, 27'd0, 1'b1, 18'd131071,
      27'b1_00000_00011_11000_10001_00011_1, 1'b0, 1'b0},
    '{MODE_ENCODE, 17'd100000, 27'd0, 1'b1, 18'd100000,
      27'b1_00000_11000_11000_11000_11000_1, 1'b0, 1'b0},
    '{MODE_ENCODE, 17'd12345, 27'h2AAAAAA, 1'b0, 18'd0, 27'd0, 1'b0, 1'b0},
    '{MODE_ENCODE, 17'd67890, 27'd0, 1'b0, 18'd0, 27'd0, 1'b0, 1'b0},
    '{MODE_ENCODE, 17'd65536, 27'h5555555, 1'b0, 18'd0, 27'd0, 1'b0, 1'b0},
    '{MODE_DECODE, 17'd0, 27'd0, 1'b1, 18'd0, 27'd0, 1'b1, 1'b0},
    '{MODE_DECODE, 17'd131071, 27'h7FFFFFF, 1'b1, 18'd155554, 27'h7FFFFFF, 1'b0, 1'b1},
    '{MODE_DECODE, 17'd0, 27'b1_11000_11000_11000_11000_11000_1, 1'b1, 18'd0,
      27'b1_11000_11000_11000_11000_11000_1, 1'b0, 1'b0},
    '{MODE_DECODE, 17'd77, 27'b1_00011_00101_00110_01001_01010_1, 1'b0,
      18'd0, 27'd0, 1'b0, 1'b0},
    '{MODE_DECODE, 17'd0, 27'b0_10100_10100_10100_10100_10100_1, 1'b1, 18'd99999,
      27'b0_10100_10100_10100_10100_10100_1, 1'b1, 1'b0},
    '{MODE_DECODE, 17'd0, 27'b1_10100_10100_10100_10100_10100_0, 1'b1, 18'd99999,
      27'b1_10100_10100_10100_10100_10100_0, 1'b1, 1'b0},
    '{MODE_DECODE, 17'd0, 27'b1_10110_00011_00011_00011_00011_1, 1'b0,
      18'd0, 27'd0, 1'b0, 1'b0},
    '{MODE_DECODE, 17'd0, 27'b1_11010_00101_11100_00110_01001_1, 1'b0,
      18'd0, 27'd0, 1'b0, 1'b0},
    '{MODE_DECODE, 17'd0, 27'b1_00001_00001_00001_00001_00001_1, 1'b1, 18'd0,
      27'b1_00001_00001_00001_00001_00001_1, 1'b0, 1'b0},
    '{MODE_DECODE, 17'd0, 27'b1_11000_11000_11000_11000_10110_1, 1'b0,
      18'd0, 27'd0, 1'b0, 1'b0},
    '{MODE_ENCODE, 17'd9, 27'd0, 1'b0, 18'd0, 27'd0, 1'b0, 1'b0},
    '{MODE_DECODE, 17'd99999, 27'h5555555, 1'b0, 18'd0, 27'd0, 1'b0, 1'b0},
    '{MODE_ENCODE, 17'd99998, 27'd0, 1'b0, 18'd0, 27'd0, 1'b0, 1'b0}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 mode = MODE_ENCODE;
  logic [ZIP_IN_W-1:0]  zip_in = '0;
  logic [BARS_W-1:0]    bars_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ZIP_OUT_W-1:0] zip_out;
  logic [BARS_W-1:0]    bars_out;
  logic                 bad_frame;
  logic                 bad_group;

  postnet_word_t expected_words [$];
  bit            calm = 1'b0;
  int            mismatch_cnt = 0;
  int            checked_cnt = 0;
  int            flagged_cnt = 0;
  int            encode_cnt = 0;
  int            decode_cnt = 0;

  postnet_zip_bar_codec DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .zip_in    (zip_in),
    .bars_in   (bars_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .zip_out   (zip_out),
    .bars_out  (bars_out),
    .bad_frame (bad_frame),
    .bad_group (bad_group)
  );

  // 2 ns clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // expected conversion of one word
  function automatic postnet_word_t predict_postnet(input logic m,
                                                    input logic [ZIP_IN_W-1:0] z,
                                                    input logic [BARS_W-1:0] b);
    postnet_word_t      r;
    int unsigned        rest;
    int unsigned        digit;
    int unsigned        sum;
    int unsigned        value;
    logic [GROUP_W-1:0] grp;
    r = '0;
    if (m == MODE_ENCODE) begin
      // frame bars, then digits from the last group back to the first
      r.zip = ZIP_OUT_W'(z);
      r.bars[BARS_W-1] = 1'b1;
      r.bars[0] = 1'b1;
      rest = z;
      for (int k = NUM_GROUPS - 1; k >= 0; k--) begin
        if (k > 0) begin
          digit = rest % 10;
          rest = rest / 10;
        end else begin
          digit = rest;
        end
        r.bars[21 - 5 * k +: GROUP_W] = (digit < 10) ? TWO_OF_FIVE[digit] : '0;
      end
    end else begin
      // 7-4-2-1-0 weights, eleven reads as zero, digits combined in decimal
      value = 0;
      for (int k = 0; k < NUM_GROUPS; k++) begin
        grp = b[21 - 5 * k +: GROUP_W];
        sum = 7 * grp[4] + 4 * grp[3] + 2 * grp[2] + grp[1];
        if (sum == 11) begin
          sum = 0;
        end
        if (sum > 9) begin
          r.bad_group = 1'b1;
        end
        value = value * 10 + sum;
      end
      r.zip = ZIP_OUT_W'(value);
      r.bars = b;
      r.bad_frame = !b[BARS_W-1] || !b[0];
    end
    return r;
  endfunction

  // present one word, note its result, hold until taken
  task automatic send_word(input logic m, input logic [ZIP_IN_W-1:0] z,
                           input logic [BARS_W-1:0] b, input postnet_word_t want);
    while (!calm && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    zip_in <= z;
    bars_in <= b;
    expected_words.push_back(want);
    if (m == MODE_ENCODE) begin
      encode_cnt++;
    end else begin
      decode_cnt++;
    end
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  // hold off the sender until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // output side stalls at random, except in the calm stretch
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 10);
  end

  // compare each taken word with the oldest expected word
  always @(posedge clk) begin
    postnet_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: zip_out %0d bars_out %h",
               zip_out, bars_out);
        mismatch_cnt++;
      end else begin
        want = expected_words.pop_front();
        checked_cnt++;
        if (want.bad_frame || want.bad_group) begin
          flagged_cnt++;
        end
        if (zip_out !== want.zip) begin
          $error("zip_out: expected %0d, actual %0d", want.zip, zip_out);
          mismatch_cnt++;
        end
        if (bars_out !== want.bars) begin
          $error("bars_out: expected %b, actual %b", want.bars, bars_out);
          mismatch_cnt++;
        end
        if (bad_frame !== want.bad_frame) begin
          $error("bad_frame: expected %b, actual %b", want.bad_frame, bad_frame);
          mismatch_cnt++;
        end
        if (bad_group !== want.bad_group) begin
          $error("bad_group: expected %b, actual %b", want.bad_group, bad_group);
          mismatch_cnt++;
        end
      end
    end
  end

  // stimulus
  initial begin
    vector_row_t          row;
    postnet_word_t        want;
    logic                 m;
    logic [ZIP_IN_W-1:0]  z;
    logic [BARS_W-1:0]    b;
    int unsigned          pick;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed vectors
    for (int i = 0; i < NUM_ROWS; i++) begin
      row = VECTORS[i];
      if (row.chk) begin
        want = '{row.ezip, row.ebars, row.ebf, row.ebg};
      end else begin
        want = predict_postnet(row.mode, row.zip, row.bars);
      end
      send_word(row.mode, row.zip, row.bars, want);
    end
    drain_results();

    // random words, mostly well-formed codes with some damage and noise
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      calm = (i >= CALM_FIRST) && (i <= CALM_LAST);
      if (i == DRAIN_AT) begin
        drain_results();
      end
      pick = $urandom_range(99);
      z = ZIP_IN_W'($urandom_range(131071));
      b = BARS_W'($urandom());
      if (pick < 35) begin
        m = MODE_ENCODE;
        z = ZIP_IN_W'($urandom_range(99999));
      end else if (pick < 42) begin
        m = MODE_ENCODE;
        z = ZIP_IN_W'($urandom_range(131071, 100000));
      end else if (pick < 88) begin
        m = MODE_DECODE;
        want = predict_postnet(MODE_ENCODE, ZIP_IN_W'($urandom_range(99999)), '0);
        b = want.bars;
        if (pick >= 75) begin
          b[$urandom_range(BARS_W - 1)] ^= 1'b1;
          if ($urandom_range(1) == 1) begin
            b[$urandom_range(BARS_W - 1)] ^= 1'b1;
          end
        end
      end else begin
        m = MODE_DECODE;
      end
      send_word(m, z, b, predict_postnet(m, z, b));
    end
    calm = 1'b0;
    drain_results();
    repeat (10) @(posedge clk);

    $display("checked %0d result words: %0d encodes, %0d decodes, %0d with flags raised",
             checked_cnt, encode_cnt, decode_cnt, flagged_cnt);
    if (mismatch_cnt == 0 && expected_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("watchdog expired with %0d words outstanding", expected_words.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pzb_pkg.sv
hdl/pzb_front.sv
hdl/pzb_queue.sv
hdl/pzb_back.sv
hdl/postnet_zip_bar_codec.sv
verif/tb_postnet_zip_bar_codec.sv
